[src/rdot_pkg.sv]
// Shared constants, corner/side indexing helpers and flag types for the
// rectangle/disc overlap pipeline. No dependencies; every other file imports it.
`default_nettype none

package rdot_pkg;

  localparam int COORD_BITS_DEF = 16;

  // Register stages of the pipeline, from the input register to the output register.
  localparam int PIPE_STAGES = 7;
  localparam int STG_DIFF    = 0;
  localparam int STG_PROD    = 1;
  localparam int STG_SUM     = 2;
  localparam int STG_MAG     = 3;
  localparam int STG_PART    = 4;
  localparam int STG_WIDE    = 5;
  localparam int STG_OUT     = 6;

  localparam int NUM_CORNERS = 4;
  localparam int NUM_SIDES   = 4;
  localparam int NUM_COORD_FIELDS = 2 * (NUM_CORNERS + 1);
  localparam int OUT_TDATA_BITS   = 8;

  typedef logic [1:0] crn_idx_t;

  localparam crn_idx_t CRN_A = 2'd0;
  localparam crn_idx_t CRN_B = 2'd1;
  localparam crn_idx_t CRN_C = 2'd2;
  localparam crn_idx_t CRN_D = 2'd3;

  localparam int SIDE_AB = 0;
  localparam int SIDE_AD = 1;
  localparam int SIDE_BC = 2;
  localparam int SIDE_DC = 3;

  // Start corner of each side.
  function automatic crn_idx_t side_p(input int k);
    crn_idx_t c;
    case (k)
      SIDE_AB: c = CRN_A;
      SIDE_AD: c = CRN_A;
      SIDE_BC: c = CRN_B;
      SIDE_DC: c = CRN_D;
      default: c = CRN_A;
    endcase
    return c;
  endfunction

  // End corner of each side.
  function automatic crn_idx_t side_q(input int k);
    crn_idx_t c;
    case (k)
      SIDE_AB: c = CRN_B;
      SIDE_AD: c = CRN_D;
      SIDE_BC: c = CRN_C;
      SIDE_DC: c = CRN_C;
      default: c = CRN_B;
    endcase
    return c;
  endfunction

  // Per-item flags handed from the geometry stages to the decision stages.
  typedef struct packed {
    logic [NUM_SIDES-1:0]   window;  // closest point lies strictly inside the side
    logic [NUM_CORNERS-1:0] near;    // corner lies within the radius
  } side_flags_t;

endpackage

`default_nettype wire

[src/rdot_pipe_ctrl.sv]
// Valid bits and per-stage load enables for the rectangle/disc overlap pipeline.
// Depends on rdot_pkg for the stage count.
`default_nettype none

module rdot_pipe_ctrl
  import rdot_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   out_ready,
  output logic [PIPE_STAGES-1:0] stage_en,
  output logic [PIPE_STAGES-1:0] stage_vld
);

  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;

  // A stage may load when it is empty or when its content moves on, so
  // bubbles close up behind a stalled output.
  always_comb begin
    stage_en[PIPE_STAGES-1] = !vld_r[PIPE_STAGES-1] || out_ready;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      stage_en[i] = !vld_r[i] || stage_en[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (stage_en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < PIPE_STAGES; i++) begin
      if (stage_en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign stage_vld = vld_r;

endmodule

`default_nettype wire

[src/rdot_geom.sv]
// Geometry front end: differences, products, sums and magnitudes (four stages).
// Depends on rdot_pkg for corner/side indexing and the flag struct.
`default_nettype none

module rdot_geom
  import rdot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)
(
  input  logic                                          clk,
  input  logic                                          en_diff,
  input  logic                                          en_prod,
  input  logic                                          en_sum,
  input  logic                                          en_mag,
  input  logic [NUM_CORNERS-1:0][COORD_BITS-1:0]        corner_x,
  input  logic [NUM_CORNERS-1:0][COORD_BITS-1:0]        corner_y,
  input  logic [COORD_BITS-1:0]                         center_x,
  input  logic [COORD_BITS-1:0]                         center_y,
  input  logic [COORD_BITS-2:0]                         radius,
  output logic [2*COORD_BITS+1:0]                       rect_mag,
  output logic [NUM_SIDES-1:0][2*COORD_BITS+1:0]        cross_mag,
  output logic [NUM_SIDES-1:0][2*COORD_BITS+1:0]        len2,
  output logic [2*COORD_BITS-3:0]                       r2,
  output side_flags_t                                   flags
);

  localparam int N  = COORD_BITS;
  localparam int DW = N + 1;       // coordinate difference
  localparam int PW = 2 * DW;      // product of two differences
  localparam int XW = PW + 1;      // difference of two products
  localparam int RW = 2 * N - 2;   // radius squared

  // Stage 1: side vectors and corner-minus-center vectors.
  logic signed [DW-1:0] sx_nxt [NUM_SIDES];
  logic signed [DW-1:0] sy_nxt [NUM_SIDES];
  logic signed [DW-1:0] gx_nxt [NUM_CORNERS];
  logic signed [DW-1:0] gy_nxt [NUM_CORNERS];
  logic signed [DW-1:0] sx_r   [NUM_SIDES];
  logic signed [DW-1:0] sy_r   [NUM_SIDES];
  logic signed [DW-1:0] gx_r   [NUM_CORNERS];
  logic signed [DW-1:0] gy_r   [NUM_CORNERS];
  logic [N-2:0]         rad_r;

  // Stage 2: products.
  logic signed [PW-1:0] rect_p1_r, rect_p2_r;
  logic signed [PW-1:0] xp1_r  [NUM_SIDES];
  logic signed [PW-1:0] xp2_r  [NUM_SIDES];
  logic signed [PW-1:0] sqx_r  [NUM_SIDES];
  logic signed [PW-1:0] sqy_r  [NUM_SIDES];
  logic signed [PW-1:0] dp1_r  [NUM_SIDES];
  logic signed [PW-1:0] dp2_r  [NUM_SIDES];
  logic signed [PW-1:0] gsqx_r [NUM_CORNERS];
  logic signed [PW-1:0] gsqy_r [NUM_CORNERS];
  logic [RW-1:0]        r2_s2_r;

  // Stage 3: cross products, squared lengths, dot products, squared distances.
  logic signed [XW-1:0] rect_x_r;
  logic signed [XW-1:0] crs_r   [NUM_SIDES];
  logic signed [XW-1:0] dot_r   [NUM_SIDES];
  logic [PW-1:0]        len2_s3_r [NUM_SIDES];
  logic [PW-1:0]        dist2_r [NUM_CORNERS];
  logic [RW-1:0]        r2_s3_r;

  // Stage 4: magnitudes and flags.
  logic signed [XW-1:0] rect_neg;
  logic signed [XW-1:0] crs_neg [NUM_SIDES];
  logic signed [XW:0]   span    [NUM_SIDES];
  logic [PW-1:0]        rect_mag_nxt;
  logic [PW-1:0]        cross_mag_nxt [NUM_SIDES];
  side_flags_t          flags_nxt;
  logic [PW-1:0]        rect_mag_r;
  logic [NUM_SIDES-1:0][PW-1:0] cross_mag_r;
  logic [NUM_SIDES-1:0][PW-1:0] len2_r;
  logic [RW-1:0]        r2_r;
  side_flags_t          flags_r;

  always_comb begin
    for (int k = 0; k < NUM_SIDES; k++) begin
      sx_nxt[k] = {corner_x[side_q(k)][N-1], corner_x[side_q(k)]}
                - {corner_x[side_p(k)][N-1], corner_x[side_p(k)]};
      sy_nxt[k] = {corner_y[side_q(k)][N-1], corner_y[side_q(k)]}
                - {corner_y[side_p(k)][N-1], corner_y[side_p(k)]};
    end
    for (int c = 0; c < NUM_CORNERS; c++) begin
      gx_nxt[c] = {corner_x[c][N-1], corner_x[c]} - {center_x[N-1], center_x};
      gy_nxt[c] = {corner_y[c][N-1], corner_y[c]} - {center_y[N-1], center_y};
    end
  end

  // The side cross product cross(side, corner P - center) is both the doubled
  // triangle area for the inside test and the numerator of the side distance.
  always_comb begin
    rect_neg = -rect_x_r;
    rect_mag_nxt = rect_x_r[XW-1] ? rect_neg[PW-1:0] : rect_x_r[PW-1:0];
    for (int k = 0; k < NUM_SIDES; k++) begin
      crs_neg[k] = -crs_r[k];
      cross_mag_nxt[k] = crs_r[k][XW-1] ? crs_neg[k][PW-1:0] : crs_r[k][PW-1:0];
      // Closest point strictly between the ends: dot < 0 and -dot < len^2.
      span[k] = {dot_r[k][XW-1], dot_r[k]} + {2'b00, len2_s3_r[k]};
      flags_nxt.window[k] = dot_r[k][XW-1] && !span[k][XW] && (span[k] != '0);
    end
    for (int c = 0; c < NUM_CORNERS; c++) begin
      flags_nxt.near[c] = dist2_r[c] <= {{(PW-RW){1'b0}}, r2_s3_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en_diff) begin
      for (int k = 0; k < NUM_SIDES; k++) begin
        sx_r[k] <= sx_nxt[k];
        sy_r[k] <= sy_nxt[k];
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
        gx_r[c] <= gx_nxt[c];
        gy_r[c] <= gy_nxt[c];
      end
      rad_r <= radius;
    end

    if (en_prod) begin
      rect_p1_r <= sx_r[SIDE_AB] * sy_r[SIDE_AD];
      rect_p2_r <= sy_r[SIDE_AB] * sx_r[SIDE_AD];
      for (int k = 0; k < NUM_SIDES; k++) begin
        xp1_r[k] <= sx_r[k] * gy_r[side_p(k)];
        xp2_r[k] <= sy_r[k] * gx_r[side_p(k)];
        sqx_r[k] <= sx_r[k] * sx_r[k];
        sqy_r[k] <= sy_r[k] * sy_r[k];
        dp1_r[k] <= gx_r[side_p(k)] * sx_r[k];
        dp2_r[k] <= gy_r[side_p(k)] * sy_r[k];
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
        gsqx_r[c] <= gx_r[c] * gx_r[c];
        gsqy_r[c] <= gy_r[c] * gy_r[c];
      end
      r2_s2_r <= rad_r * rad_r;
    end

    if (en_sum) begin
      rect_x_r <= {rect_p1_r[PW-1], rect_p1_r} - {rect_p2_r[PW-1], rect_p2_r};
      for (int k = 0; k < NUM_SIDES; k++) begin
        crs_r[k]     <= {xp1_r[k][PW-1], xp1_r[k]} - {xp2_r[k][PW-1], xp2_r[k]};
        dot_r[k]     <= {dp1_r[k][PW-1], dp1_r[k]} + {dp2_r[k][PW-1], dp2_r[k]};
        len2_s3_r[k] <= sqx_r[k] + sqy_r[k];
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
        dist2_r[c] <= gsqx_r[c] + gsqy_r[c];
      end
      r2_s3_r <= r2_s2_r;
    end

    if (en_mag) begin
      rect_mag_r <= rect_mag_nxt;
      for (int k = 0; k < NUM_SIDES; k++) begin
        cross_mag_r[k] <= cross_mag_nxt[k];
        len2_r[k]      <= len2_s3_r[k];
      end
      r2_r    <= r2_s3_r;
      flags_r <= flags_nxt;
    end
  end

  assign rect_mag  = rect_mag_r;
  assign cross_mag = cross_mag_r;
  assign len2      = len2_r;
  assign r2        = r2_r;
  assign flags     = flags_r;

endmodule

`default_nettype wire

[src/rdot_wide_mul.sv]
// Two-stage unsigned multiplier: four half-width partial products, then their sum.
// Depends on rdot_pkg for the default operand widths; no other modules.
`default_nettype none

module rdot_wide_mul
  import rdot_pkg::*;
#(
  parameter int A_BITS = 2 * COORD_BITS_DEF + 2,
  parameter int B_BITS = 2 * COORD_BITS_DEF + 2
)
(
  input  logic                     clk,
  input  logic                     en_part,
  input  logic                     en_sum,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] prod
);

  localparam int AL = (A_BITS + 1) / 2;
  localparam int AH = A_BITS - AL;
  localparam int BL = (B_BITS + 1) / 2;
  localparam int BH = B_BITS - BL;
  localparam int PB = A_BITS + B_BITS;

  logic [AL+BL-1:0] ll_r;
  logic [AL+BH-1:0] lh_r;
  logic [AH+BL-1:0] hl_r;
  logic [AH+BH-1:0] hh_r;
  logic [PB-1:0]    prod_nxt;
  logic [PB-1:0]    prod_r;

  always_ff @(posedge clk) begin
    if (en_part) begin
      ll_r <= a[AL-1:0] * b[BL-1:0];
      lh_r <= a[AL-1:0] * b[B_BITS-1:BL];
      hl_r <= a[A_BITS-1:AL] * b[BL-1:0];
      hh_r <= a[A_BITS-1:AL] * b[B_BITS-1:BL];
    end
    if (en_sum) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_nxt = PB'(ll_r)
                  + (PB'(lh_r) << BL)
                  + (PB'(hl_r) << AL)
                  + (PB'(hh_r) << (AL + BL));

  assign prod = prod_r;

endmodule

`default_nettype wire

[src/rdot_decide.sv]
// Decision stages: inside test, per-side flag alignment and the final hit register.
// Depends on rdot_pkg for corner/side indexing and the flag struct.
`default_nettype none

module rdot_decide
  import rdot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)
(
  input  logic                                   clk,
  input  logic                                   en_part,
  input  logic                                   en_wide,
  input  logic                                   en_out,
  input  logic [2*COORD_BITS+1:0]                rect_mag,
  input  logic [NUM_SIDES-1:0][2*COORD_BITS+1:0] cross_mag,
  input  side_flags_t                            flags,
  input  logic [NUM_SIDES-1:0][4*COORD_BITS+3:0] cross_sq,
  input  logic [NUM_SIDES-1:0][4*COORD_BITS-1:0] rad_len,
  output logic                                   hit
);

  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = PW + 2;            // sum of four magnitudes
  localparam int CW = 2 * PW;            // squared cross product
  localparam int QW = 4 * COORD_BITS;    // radius^2 * length^2

  logic [SW-1:0]        area_sum;
  logic                 inside_nxt;
  logic [NUM_SIDES-1:0] end_near_nxt;
  logic [NUM_SIDES-1:0] close;

  logic                 inside5_r, inside6_r;
  logic [NUM_SIDES-1:0] end_near5_r, end_near6_r;
  logic [NUM_SIDES-1:0] window5_r, window6_r;
  logic                 hit_r;

  // Center inside: the four doubled triangle areas add up to twice the
  // rectangle area; a degenerate rectangle never counts as inside.
  always_comb begin
    area_sum = SW'(cross_mag[SIDE_AB]) + SW'(cross_mag[SIDE_AD])
             + SW'(cross_mag[SIDE_BC]) + SW'(cross_mag[SIDE_DC]);
    inside_nxt = (rect_mag != '0) && (area_sum == {1'b0, rect_mag, 1'b0});
    for (int k = 0; k < NUM_SIDES; k++) begin
      end_near_nxt[k] = flags.near[side_p(k)] || flags.near[side_q(k)];
    end
  end

  // Perpendicular distance within the radius: cross^2 <= r^2 * len^2.
  always_comb begin
    for (int k = 0; k < NUM_SIDES; k++) begin
      close[k] = cross_sq[k] <= {{(CW-QW){1'b0}}, rad_len[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en_part) begin
      inside5_r   <= inside_nxt;
      end_near5_r <= end_near_nxt;
      window5_r   <= flags.window;
    end
    if (en_wide) begin
      inside6_r   <= inside5_r;
      end_near6_r <= end_near5_r;
      window6_r   <= window5_r;
    end
    if (en_out) begin
      hit_r <= inside6_r || (|end_near6_r) || (|(window6_r & close));
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

[src/rectangle_disc_overlap_test.sv]
// Top level of the rectangle/disc overlap test: stream ports, field unpacking,
// and the pipeline built from rdot_pipe_ctrl, rdot_geom, rdot_wide_mul and rdot_decide.
// Depends on rdot_pkg.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------------
//   in_     | input     | in_tvalid/in_tready  | rectangle corners, disc center, radius
//   out_    | output    | out_tvalid/out_tready| hit flag
//
// One item is accepted per clock cycle unless every stage holds an item and
// out_tready is low. Every item passes through seven register stages:
// differences, products, sums, magnitudes, partial products of the two
// wide squares, their sums, and the final compare.
// Reset (rst_n low at a clock edge) clears only the stage valid bits.
// A stall on out_tready holds the output item; earlier stages keep filling
// their empty slots, and in_tready falls only when every stage holds an item.
`default_nettype none

module rectangle_disc_overlap_test
  import rdot_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
)
(
  input  logic                                                     clk,
  input  logic                                                     rst_n,
  input  logic                                                     in_tvalid,
  output logic                                                     in_tready,
  // in_tdata, lowest bit first: corner_a_x, corner_a_y, corner_b_x, corner_b_y,
  // corner_c_x, corner_c_y, corner_d_x, corner_d_y, center_x, center_y (COORD_BITS
  // each, signed), radius (COORD_BITS-1, unsigned), zero padding to whole bytes.
  input  logic [(((NUM_COORD_FIELDS+1)*COORD_BITS-1+7)/8)*8-1:0]    in_tdata,
  output logic                                                     out_tvalid,
  input  logic                                                     out_tready,
  // out_tdata, lowest bit first: hit, zero padding.
  output logic [OUT_TDATA_BITS-1:0]                                out_tdata
);

  localparam int N  = COORD_BITS;
  localparam int PW = 2 * N + 2;
  localparam int RW = 2 * N - 2;

  logic [PIPE_STAGES-1:0] stage_en;
  logic [PIPE_STAGES-1:0] stage_vld;

  logic [NUM_CORNERS-1:0][N-1:0] corner_x;
  logic [NUM_CORNERS-1:0][N-1:0] corner_y;
  logic [N-1:0]                  center_x;
  logic [N-1:0]                  center_y;
  logic [N-2:0]                  radius;

  logic [PW-1:0]                 rect_mag;
  logic [NUM_SIDES-1:0][PW-1:0]  cross_mag;
  logic [NUM_SIDES-1:0][PW-1:0]  len2;
  logic [RW-1:0]                 r2;
  side_flags_t                   flags;

  logic [NUM_SIDES-1:0][2*PW-1:0]  cross_sq;
  logic [NUM_SIDES-1:0][RW+PW-1:0] rad_len;

  logic hit;

  // Field unpacking: corners in A, B, C, D order, x before y.
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      corner_x[c] = in_tdata[2*c*N +: N];
      corner_y[c] = in_tdata[(2*c+1)*N +: N];
    end
    center_x = in_tdata[2*NUM_CORNERS*N +: N];
    center_y = in_tdata[(2*NUM_CORNERS+1)*N +: N];
    radius   = in_tdata[NUM_COORD_FIELDS*N +: N-1];
  end

  rdot_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .stage_en  (stage_en),
    .stage_vld (stage_vld)
  );

  // Stages one to four: vectors, products, sums, magnitudes and flags.
  rdot_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .en_diff   (stage_en[STG_DIFF]),
    .en_prod   (stage_en[STG_PROD]),
    .en_sum    (stage_en[STG_SUM]),
    .en_mag    (stage_en[STG_MAG]),
    .corner_x  (corner_x),
    .corner_y  (corner_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .rect_mag  (rect_mag),
    .cross_mag (cross_mag),
    .len2      (len2),
    .r2        (r2),
    .flags     (flags)
  );

  // Stages five and six: the squared cross product and radius^2 * length^2 of
  // every side are too wide for one multiplier, so each is split in halves.
  for (genvar k = 0; k < NUM_SIDES; k++) begin : g_side
    rdot_wide_mul #(
      .A_BITS (PW),
      .B_BITS (PW)
    ) u_cross_sq (
      .clk     (clk),
      .en_part (stage_en[STG_PART]),
      .en_sum  (stage_en[STG_WIDE]),
      .a       (cross_mag[k]),
      .b       (cross_mag[k]),
      .prod    (cross_sq[k])
    );

    rdot_wide_mul #(
      .A_BITS (RW),
      .B_BITS (PW)
    ) u_rad_len (
      .clk     (clk),
      .en_part (stage_en[STG_PART]),
      .en_sum  (stage_en[STG_WIDE]),
      .a       (r2),
      .b       (len2[k]),
      .prod    (rad_len[k])
    );
  end

  // Stages five to seven: inside test, flag alignment, final hit.
  rdot_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .clk       (clk),
    .en_part   (stage_en[STG_PART]),
    .en_wide   (stage_en[STG_WIDE]),
    .en_out    (stage_en[STG_OUT]),
    .rect_mag  (rect_mag),
    .cross_mag (cross_mag),
    .flags     (flags),
    .cross_sq  (cross_sq),
    .rad_len   (rad_len),
    .hit       (hit)
  );

  assign in_tready  = stage_en[STG_DIFF];
  assign out_tvalid = stage_vld[STG_OUT];
  assign out_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, hit};

  // The input is refused exactly when every stage is full and the output stalls.
  a_ready_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == !((&stage_vld) && !out_tready))
    else $error("in_tready does not match pipeline occupancy");

  // Items in flight change only by accepted inputs and delivered outputs.
  a_occupancy : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> $countones(stage_vld) == $past($countones(stage_vld))
             + $past(in_tvalid && in_tready) - $past(out_tvalid && out_tready))
    else $error("pipeline lost or duplicated an item");

endmodule

`default_nettype wire
